// File: rtl/rnlp_pkg.sv
// Package with the symbol codes, numeral table and register map of the Roman numeral LED placer.
`default_nettype none
package rnlp_pkg;

  localparam int unsigned LED_COUNT_DEFAULT = 60;
  localparam int unsigned MAX_SYMBOLS = 8;
  localparam int unsigned TABLE_LAST = 6;
  localparam logic [6:0] NUMBER_MAX = 7'd99;

  localparam logic [23:0] COLOUR_ONE_RESET = 24'h0000FF;
  localparam logic [23:0] COLOUR_FIVE_RESET = 24'h008000;
  localparam logic [23:0] COLOUR_TEN_RESET = 24'hFF0000;
  localparam logic [23:0] COLOUR_FIFTY_RESET = 24'hFFFF00;

  localparam logic [7:0] REG_COLOUR_ONE = 8'd0;
  localparam logic [7:0] REG_COLOUR_FIVE = 8'd1;
  localparam logic [7:0] REG_COLOUR_TEN = 8'd2;
  localparam logic [7:0] REG_COLOUR_FIFTY = 8'd3;

  typedef enum logic [1:0] {
    SYM_I,
    SYM_V,
    SYM_X,
    SYM_L
  } sym_t;

  typedef struct packed {
    logic [5:0] value;
    sym_t first;
    logic two;
    sym_t second;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_CENTER,
    ST_EMIT
  } state_t;

  function automatic entry_t table_entry(input logic [2:0] k);
    entry_t e;
    unique case (k)
      3'd0: e = '{value: 6'd50, first: SYM_L, two: 1'b0, second: SYM_I};
      3'd1: e = '{value: 6'd40, first: SYM_X, two: 1'b1, second: SYM_L};
      3'd2: e = '{value: 6'd10, first: SYM_X, two: 1'b0, second: SYM_I};
      3'd3: e = '{value: 6'd9, first: SYM_I, two: 1'b1, second: SYM_X};
      3'd4: e = '{value: 6'd5, first: SYM_V, two: 1'b0, second: SYM_I};
      3'd5: e = '{value: 6'd4, first: SYM_I, two: 1'b1, second: SYM_V};
      default: e = '{value: 6'd1, first: SYM_I, two: 1'b0, second: SYM_I};
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// File: rtl/roman_numeral_led_placer.sv
// Top level of the Roman numeral LED placer: converter, centering and LED write sequencer.
//
// An input item on the s_ channel carries a number, a section start and a section length.
// The number (clamped to 99) is broken into Roman symbols by greedy subtraction, and one
// LED write per symbol leaves on the m_ channel, in reading order, with m_tlast on the last.
// A number of zero gives no output item at all.
// The cfg channel writes the four symbol colours; it is always ready and must only be
// used while the block is idle.
// One item is worked at a time and s_tready is high only when the block is idle.
// Conversion runs one step of a shared compare-and-subtract unit per cycle over the
// numeral table, then the centered start is computed in its own state, ST_CENTER.
// The writes then leave from an output register, one per cycle while the receiver is ready.
// When the receiver stalls, the output register holds its write and the sequencer waits.
// Synchronous reset returns the block to idle, drops m_tvalid and restores the default
// colours.
`default_nettype none
module roman_numeral_led_placer #(
  parameter int unsigned LED_COUNT = rnlp_pkg::LED_COUNT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // number[6:0], start_index[14:7], section_length[22:15], 0
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // led_index[7:0], colour[31:8]
  output logic             m_tuser,  // index_ok
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam logic [7:0] LedCount = LED_COUNT[7:0];

  rnlp_pkg::state_t state, state_next;
  logic [6:0] num, num_next;
  logic [2:0] k, k_next;
  logic [3:0] count, count_next;
  logic [3:0] pos, pos_next;
  logic [7:0] start, start_next;
  logic [7:0] length;
  logic m_tvalid_next;
  logic [7:0] led_index, led_index_next;
  logic [23:0] colour, colour_next;
  logic index_ok, index_ok_next;
  logic last, last_next;

  logic [23:0] colour_one, colour_five, colour_ten, colour_fifty;
  rnlp_pkg::sym_t syms [rnlp_pkg::MAX_SYMBOLS];

  rnlp_pkg::entry_t entry;
  logic [7:0] sub;
  logic push_one, push_two;
  logic load;
  logic [8:0] diff;
  logic [6:0] number_in;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == rnlp_pkg::ST_IDLE);
  assign m_tdata = {colour, led_index};
  assign m_tuser = index_ok;
  assign m_tlast = last;

  assign number_in = (s_tdata[6:0] > rnlp_pkg::NUMBER_MAX) ? rnlp_pkg::NUMBER_MAX
                                                         : s_tdata[6:0];
  assign entry = rnlp_pkg::table_entry(k);
  assign sub = {1'b0, num} - {2'b00, entry.value};
  assign diff = {1'b0, length} - {4'b0000, count, 1'b0};

  always_comb begin
    state_next = state;
    num_next = num;
    k_next = k;
    count_next = count;
    pos_next = pos;
    start_next = start;
    led_index_next = led_index;
    colour_next = colour;
    index_ok_next = index_ok;
    last_next = last;
    push_one = 1'b0;
    push_two = 1'b0;
    load = 1'b0;
    unique case (state)
      rnlp_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          num_next = number_in;
          start_next = s_tdata[14:7];
          k_next = '0;
          count_next = '0;
          pos_next = '0;
          state_next = rnlp_pkg::ST_CONVERT;
        end
      end
      rnlp_pkg::ST_CONVERT: begin
        if (num == '0) begin
          state_next = rnlp_pkg::ST_CENTER;
        end else if (!sub[7]) begin
          num_next = sub[6:0];
          push_one = (count < 4'(rnlp_pkg::MAX_SYMBOLS));
          push_two = entry.two && (count + 4'd1 < 4'(rnlp_pkg::MAX_SYMBOLS));
          count_next = count + {3'b000, push_one} + {3'b000, push_two};
        end else begin
          k_next = k + 3'd1;
        end
      end
      rnlp_pkg::ST_CENTER: begin
        start_next = start + diff[8:1];
        state_next = rnlp_pkg::ST_EMIT;
      end
      rnlp_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          if (pos < count) begin
            load = 1'b1;
            led_index_next = LedCount - start;
            index_ok_next = (led_index_next < LedCount);
            last_next = (pos + 4'd1 == count);
            case (syms[pos[2:0]])
              rnlp_pkg::SYM_I: colour_next = colour_one;
              rnlp_pkg::SYM_V: colour_next = colour_five;
              rnlp_pkg::SYM_X: colour_next = colour_ten;
              default: colour_next = colour_fifty;
            endcase
            start_next = start + 8'd2;
            pos_next = pos + 4'd1;
          end else begin
            state_next = rnlp_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = rnlp_pkg::ST_IDLE;
    endcase
    m_tvalid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rnlp_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      count <= '0;
      pos <= '0;
    end else begin
      state <= state_next;
      m_tvalid <= m_tvalid_next;
      count <= count_next;
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    num <= num_next;
    k <= k_next;
    start <= start_next;
    led_index <= led_index_next;
    colour <= colour_next;
    index_ok <= index_ok_next;
    last <= last_next;
    if (state == rnlp_pkg::ST_IDLE && s_tvalid) begin
      length <= s_tdata[22:15];
    end
    if (push_one) begin
      syms[count[2:0]] <= entry.first;
    end
    if (push_two) begin
      syms[count[2:0] + 3'd1] <= entry.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_one <= rnlp_pkg::COLOUR_ONE_RESET;
      colour_five <= rnlp_pkg::COLOUR_FIVE_RESET;
      colour_ten <= rnlp_pkg::COLOUR_TEN_RESET;
      colour_fifty <= rnlp_pkg::COLOUR_FIFTY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rnlp_pkg::REG_COLOUR_ONE: colour_one <= cfg_data;
        rnlp_pkg::REG_COLOUR_FIVE: colour_five <= cfg_data;
        rnlp_pkg::REG_COLOUR_TEN: colour_ten <= cfg_data;
        rnlp_pkg::REG_COLOUR_FIFTY: colour_fifty <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == rnlp_pkg::ST_IDLE) |-> !m_tvalid)
    else $error("output item pending while idle");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= 4'(rnlp_pkg::MAX_SYMBOLS))
    else $error("symbol count above maximum");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rnlp_pkg::ST_EMIT) |-> (pos <= count))
    else $error("emit position beyond symbol count");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (state == rnlp_pkg::ST_IDLE))
    else $error("block not idle after final item");

  a_start_conv: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == rnlp_pkg::ST_CONVERT && count == '0))
    else $error("conversion did not start after input item");
`endif

endmodule
`default_nettype wire
